/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types, codes and helpers for the fixed-point ALU
// Word layouts, function codes, command class and saturation helpers.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FPA_FRAC_BITS_DEF = 8;
    // one quotient bit per back-end step, bits 32 down to 0
    localparam int FPA_DIV_STEPS     = 33;

    // function codes
    localparam logic [4:0] FN_ADD       = 5'd0;
    localparam logic [4:0] FN_SUB       = 5'd1;
    localparam logic [4:0] FN_MUL       = 5'd2;
    localparam logic [4:0] FN_DIV       = 5'd3;
    localparam logic [4:0] FN_MIN       = 5'd4;
    localparam logic [4:0] FN_MAX       = 5'd5;
    localparam logic [4:0] FN_LT        = 5'd6;
    localparam logic [4:0] FN_GT        = 5'd7;
    localparam logic [4:0] FN_LE        = 5'd8;
    localparam logic [4:0] FN_GE        = 5'd9;
    localparam logic [4:0] FN_EQ        = 5'd10;
    localparam logic [4:0] FN_NE        = 5'd11;
    localparam logic [4:0] FN_PRE_INC   = 5'd12;
    localparam logic [4:0] FN_POST_INC  = 5'd13;
    localparam logic [4:0] FN_PRE_DEC   = 5'd14;
    localparam logic [4:0] FN_POST_DEC  = 5'd15;
    localparam logic [4:0] FN_TO_INT    = 5'd16;
    localparam logic [4:0] FN_FROM_INT  = 5'd17;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               truth;
        logic               overflow;
        logic               div_by_zero;
    } fpa_out_t;

    // how the back end treats a command
    typedef enum logic [1:0] {
        CLS_DIRECT,
        CLS_MUL,
        CLS_DIV
    } fpa_class_t;

    // command word passed from front end to back end
    typedef struct packed {
        fpa_class_t  cls;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        fpa_out_t    direct;
    } fpa_cmd_t;

    // magnitude of a two's complement word (-2^31 gives 2^31)
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // saturate a 33-bit signed sum: {overflow, value}
    function automatic logic [32:0] sat33(input logic [32:0] s);
        if (s[32] != s[31])
            return {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        return {1'b0, s[31:0]};
    endfunction

    // build a value from sign and magnitude, saturating: {overflow, value}
    function automatic logic [32:0] sat_sm(input logic neg, input logic [63:0] m);
        if (neg) begin
            if (m > 64'h0000_0000_8000_0000)
                return {1'b1, 32'h8000_0000};
            return {1'b0, ~m[31:0] + 32'd1};
        end
        if (m > 64'h0000_0000_7FFF_FFFF)
            return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, m[31:0]};
    endfunction

endpackage

/* rtl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front: command decode and classification
// Works out every operation directly but multiply and nonzero divide, and tags
// those two for the back end.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS_DEF
) (
    input  logic              start,
    input  fpa_pkg::fpa_in_t  op,
    input  logic              full,
    output logic              busy,
    output logic              push,
    output fpa_pkg::fpa_cmd_t cmd
);
    import fpa_pkg::*;

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [32:0]        sum_s;
    logic [32:0]        dif_s;
    logic [32:0]        inc_s;
    logic [32:0]        dec_s;
    logic               fi_ovf;
    logic [31:0]        fi_val;

    // handshake: take a word whenever the queue has room
    assign busy = full;
    assign push = start && !full;

    assign a = op.operand_a;
    assign b = op.operand_b;

    // 33-bit sums for saturation
    assign sum_s = {a[31], a} + {b[31], b};
    assign dif_s = {a[31], a} - {b[31], b};
    assign inc_s = {a[31], a} + 33'd1;
    assign dec_s = {a[31], a} - 33'd1;

    // from_int fits when the top FRAC_BITS+1 bits all match the sign
    assign fi_ovf = (a[31:31-FRAC_BITS] != {(FRAC_BITS+1){a[31]}});
    assign fi_val = fi_ovf ? (a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           : {a[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};

    // decode
    always_comb
    begin
        cmd        = '0;
        cmd.cls    = CLS_DIRECT;
        cmd.neg    = a[31] ^ b[31];
        cmd.mag_a  = mag32(a);
        cmd.mag_b  = mag32(b);
        unique case (op.func)
            FN_ADD:      {cmd.direct.overflow, cmd.direct.result} = sat33(sum_s);
            FN_SUB:      {cmd.direct.overflow, cmd.direct.result} = sat33(dif_s);
            FN_MUL:      cmd.cls = CLS_MUL;
            FN_DIV:
            begin
                if (b == 32'sd0)
                    cmd.direct.div_by_zero = 1'b1;
                else
                    cmd.cls = CLS_DIV;
            end
            FN_MIN:      cmd.direct.result = (a <= b) ? a : b;
            FN_MAX:      cmd.direct.result = (a >= b) ? a : b;
            FN_LT:       cmd.direct.truth = (a < b);
            FN_GT:       cmd.direct.truth = (a > b);
            FN_LE:       cmd.direct.truth = (a <= b);
            FN_GE:       cmd.direct.truth = (a >= b);
            FN_EQ:       cmd.direct.truth = (a == b);
            FN_NE:       cmd.direct.truth = (a != b);
            FN_PRE_INC:  {cmd.direct.overflow, cmd.direct.result} = sat33(inc_s);
            FN_POST_INC: cmd.direct.result = a;
            FN_PRE_DEC:  {cmd.direct.overflow, cmd.direct.result} = sat33(dec_s);
            FN_POST_DEC: cmd.direct.result = a;
            FN_TO_INT:   cmd.direct.result = a >>> FRAC_BITS;
            FN_FROM_INT:
            begin
                cmd.direct.result   = fi_val;
                cmd.direct.overflow = fi_ovf;
            end
            default:     cmd.direct = '0;
        endcase
    end

endmodule

/* rtl/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue: two-word command queue
// Decouples the front end from the back-end pipeline.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fpa_pkg::fpa_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              valid,
    output fpa_pkg::fpa_cmd_t head
);
    import fpa_pkg::*;

    fpa_cmd_t    mem_reg [0:1];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        do_pop;

    assign full   = (cnt_reg == 2'd2);
    assign valid  = (cnt_reg != 2'd0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Registered 32x32 multiply with rounding, a 33-step restoring divider
// (one quotient bit per stage) and alignment of direct results.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpa_pkg::fpa_cmd_t in_cmd,
    output logic              done,
    output fpa_pkg::fpa_out_t res
);
    import fpa_pkg::*;

    localparam int NS = FPA_DIV_STEPS;

    typedef struct packed {
        fpa_class_t  cls;
        logic        neg;
        logic        hi;
        logic [31:0] rem;
        logic [32:0] q;
        logic [32:0] num_lo;
        logic [31:0] den;
        logic [63:0] prod;
        fpa_out_t    direct;
    } stg_t;

    stg_t        stg_reg  [0:NS];
    stg_t        stg_next [0:NS];
    logic [NS:0] vld_reg;
    logic        done_reg;
    fpa_out_t    res_reg;
    fpa_out_t    res_next;
    logic [63:0] num0;
    logic [63:0] prod_rnd;
    logic [32:0] mul_sat;

    assign num0     = {32'd0, in_cmd.mag_a} << FRAC_BITS;
    // rounding of the product: add half an LSB, drop fraction bits
    assign prod_rnd = (stg_reg[0].prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign mul_sat  = sat_sm(stg_reg[0].neg, prod_rnd);

    // stage 0 loads and multiplies; divider steps follow,
    // stage 1 also finishes the multiply
    always_comb
    begin
        logic [32:0] t;
        logic        ge;
        stg_next[0].cls    = in_cmd.cls;
        stg_next[0].neg    = in_cmd.neg;
        stg_next[0].hi     = ({1'b0, num0[63:33]} >= in_cmd.mag_b);
        stg_next[0].rem    = {1'b0, num0[63:33]};
        stg_next[0].q      = '0;
        stg_next[0].num_lo = num0[32:0];
        stg_next[0].den    = in_cmd.mag_b;
        stg_next[0].prod   = in_cmd.mag_a * in_cmd.mag_b;
        stg_next[0].direct = in_cmd.direct;
        for (int i = 1; i <= NS; i++)
        begin
            t  = {stg_reg[i-1].rem, stg_reg[i-1].num_lo[32]};
            ge = (t >= {1'b0, stg_reg[i-1].den});
            stg_next[i]        = stg_reg[i-1];
            stg_next[i].rem    = ge ? 32'(t - {1'b0, stg_reg[i-1].den}) : t[31:0];
            stg_next[i].q      = {stg_reg[i-1].q[31:0], ge};
            stg_next[i].num_lo = {stg_reg[i-1].num_lo[31:0], 1'b0};
            if (i == 1 && stg_reg[0].cls == CLS_MUL)
            begin
                stg_next[i].direct.result   = mul_sat[31:0];
                stg_next[i].direct.overflow = mul_sat[32];
            end
        end
    end

    // quotient rounding and final selection
    always_comb
    begin
        logic        rnd;
        logic [33:0] m;
        logic [32:0] dsat;
        rnd  = ({stg_reg[NS].rem, 1'b0} >= {1'b0, stg_reg[NS].den});
        m    = {1'b0, stg_reg[NS].q} + {33'd0, rnd};
        dsat = stg_reg[NS].hi ? sat_sm(stg_reg[NS].neg, 64'hFFFF_FFFF_FFFF_FFFF)
                              : sat_sm(stg_reg[NS].neg, {30'd0, m});
        if (stg_reg[NS].cls == CLS_DIV)
        begin
            res_next.result      = dsat[31:0];
            res_next.truth       = 1'b0;
            res_next.overflow    = dsat[32];
            res_next.div_by_zero = 1'b0;
        end
        else
            res_next = stg_reg[NS].direct;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NS-1:0], in_valid};
            done_reg <= vld_reg[NS];
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= NS; i++)
            stg_reg[i] <= stg_next[i];
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* rtl/fixed_point_alu_unit.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_unit: signed Q(32-FRAC_BITS).FRAC_BITS fixed-point ALU
// Front end decodes, a short queue decouples, a pipelined back end executes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op (func, operand_a, operand_b) and raise start. The word is taken
//   at a rising edge where start is high and busy is low.
//   Each taken word gives exactly one result word on res, marked by done for
//   one cycle; the receiver takes it at the edge ending that cycle and
//   cannot hold it off.
//   The path is the same for every function: queue, multiply/load stage,
//   33 divider steps, output register. The 33-step divider sets its length;
//   all functions share the pipeline so results leave in order.
//   Throughput: one word per cycle, back to back. busy only rises if the
//   command queue fills, which the always-draining back end never allows.
//   Reset clears the queue and all valid bits; no results follow a reset
//   until new words are taken.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fpa_pkg::fpa_in_t  op,
    output logic              done,
    output fpa_pkg::fpa_out_t res
);
    import fpa_pkg::*;

    localparam int LAT = FPA_DIV_STEPS + 3;

    logic     push;
    logic     full;
    logic     q_valid;
    fpa_cmd_t cmd;
    fpa_cmd_t head;

    // decode
    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .start (start),
        .op    (op),
        .full  (full),
        .busy  (busy),
        .push  (push),
        .cmd   (cmd)
    );

    // command queue
    fpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (q_valid),
        .full     (full),
        .valid    (q_valid),
        .head     (head)
    );

    // execution
    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_cmd   (head),
        .done     (done),
        .res      (res)
    );

    // every taken word produces its result a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after accepted word");

    // no result without a word taken earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted word");

    // divide by zero gives zero with no overflow
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.div_by_zero) |-> (res.result == 32'sd0 && !res.overflow))
        else $error("divide by zero result not clean");

    // the back end drains each cycle, so the queue never fills
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("command queue filled");

endmodule
